FILE: rtl/core/ifp_pkg.sv
// Shared constants and types for the IMU frame parser.
// No dependencies; compile first.
package ifp_pkg;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;

  localparam int FrameLen = 11;
  localparam int SumLen   = 10;
  localparam int NumAxes  = 3;
  localparam int CountW   = $clog2(FrameLen);

  typedef logic [CountW-1:0] count_t;

  // Frame status as seen on the checksum byte
  typedef struct packed {
    logic                     done;
    logic [7:0]               ftype;
    logic [NumAxes-1:0][15:0] word;
  } ifp_frame_t;

endpackage

FILE: rtl/core/ifp_if.sv
// Valid/ready channel interfaces for the IMU frame parser.
// No dependencies beyond the language.
interface ifp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifp_rec_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output rate_x, output rate_y, output rate_z,
                  output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input rate_x, input rate_y, input rate_z,
                  input roll_angle, input pitch_angle, input yaw_angle,
                  output ready);
endinterface

FILE: rtl/core/ifp_frame_asm.sv
// Frame assembler: byte counter, running checksum and frame byte store.
// Depends on ifp_pkg.
module ifp_frame_asm (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output ifp_pkg::ifp_frame_t frame
);
  import ifp_pkg::*;

  logic [7:0] frame_bytes [SumLen];
  count_t     byte_count;
  count_t     byte_count_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic       at_check;
  logic       in_frame;

  always_comb begin
    at_check = (byte_count == count_t'(SumLen));
    in_frame = (byte_count != '0) || (rx_byte == HdrByte);
  end

  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    if (step && in_frame) begin
      if (at_check) begin
        byte_count_next  = '0;
        running_sum_next = '0;
      end else begin
        byte_count_next  = byte_count + count_t'(1);
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_frame && !at_check) begin
      frame_bytes[byte_count] <= rx_byte;
    end
  end

  always_comb begin
    frame.done  = byte_valid && at_check && (rx_byte == running_sum);
    frame.ftype = frame_bytes[1];
    for (int k = 0; k < NumAxes; k++) begin
      frame.word[k] = {frame_bytes[2*k+3], frame_bytes[2*k+2]};
    end
  end

endmodule

FILE: rtl/core/imu_frame_parser.sv
// IMU serial frame parser, top level.
// Depends on ifp_pkg, ifp_if and ifp_frame_asm.
//
// rx carries one received serial byte per transfer. Frames are 11 bytes:
// header 0x55, type, six data bytes (three little-endian signed words),
// two further bytes and an 8-bit sum checksum over the first ten.
// Acceleration (0x51) and rate (0x52) frames update internal latches;
// an angle frame (0x53) with a good checksum gives one transfer on rec
// carrying latched acceleration, latched rate and the three angles.
// Bad-checksum frames, stray bytes and other types give nothing.
//
// One byte register feeds the checksum/decode logic, which writes the
// result register: a byte can be taken every cycle. An angle record becomes
// valid in the result register once its checksum byte has passed the byte register.
// A stalled rec only holds back the byte stage when that byte would
// complete another record; other bytes keep flowing.
// Reset (synchronous) closes any open frame, zeroes the latches and
// empties the byte and result registers.
module imu_frame_parser (
  input  logic      clk,
  input  logic      rst,
  ifp_byte_if.sink  rx,
  ifp_rec_if.source rec
);
  import ifp_pkg::*;

  logic                     byte_valid;
  logic [7:0]               byte_data;
  ifp_frame_t               frame;
  logic [NumAxes-1:0][15:0] accel_hold;
  logic [NumAxes-1:0][15:0] rate_hold;
  logic                     out_free;
  logic                     emit;
  logic                     stall;
  logic                     step;

  ifp_frame_asm u_asm (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .step       (step),
    .rx_byte    (byte_data),
    .frame      (frame)
  );

  always_comb begin
    out_free = !rec.valid || rec.ready;
    emit     = frame.done && (frame.ftype == TypeAngle);
    stall    = emit && !out_free;
    step     = byte_valid && !stall;
    rx.ready = !byte_valid || !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_data <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_hold <= '0;
      rate_hold  <= '0;
    end else if (step && frame.done) begin
      case (frame.ftype)
        TypeAccel: accel_hold <= frame.word;
        TypeRate:  rate_hold  <= frame.word;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else if (out_free) begin
      rec.valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rec.accel_x     <= $signed(accel_hold[0]);
      rec.accel_y     <= $signed(accel_hold[1]);
      rec.accel_z     <= $signed(accel_hold[2]);
      rec.rate_x      <= $signed(rate_hold[0]);
      rec.rate_y      <= $signed(rate_hold[1]);
      rec.rate_z      <= $signed(rate_hold[2]);
      rec.roll_angle  <= $signed(frame.word[0]);
      rec.pitch_angle <= $signed(frame.word[1]);
      rec.yaw_angle   <= $signed(frame.word[2]);
    end
  end

endmodule

FILE: rtl/core/ifp_checker.sv
// Port-level checks for imu_frame_parser, with the bind that attaches them.
// Depends on imu_frame_parser and ifp_if.
module ifp_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [143:0] out_data
);

  // record held until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("record dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("record changed while stalled");

  // byte side only ever waits on a stalled record
  a_in_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("byte input stalled without a stalled record");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("record present after reset");

endmodule

bind imu_frame_parser ifp_checker u_ifp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (rx.valid),
  .in_ready  (rx.ready),
  .out_valid (rec.valid),
  .out_ready (rec.ready),
  .out_data  ({rec.accel_x, rec.accel_y, rec.accel_z,
               rec.rate_x, rec.rate_y, rec.rate_z,
               rec.roll_angle, rec.pitch_angle, rec.yaw_angle})
);

FILE: sim/imu_frame_parser_test.sv
// Self-checking testbench for imu_frame_parser: byte stream in, angle records out.
// Depends on ifp_pkg, ifp_if and the parser RTL; a directed frame table, then
// random frame streams under four source/sink idle phases, checked by a predictor.
`timescale 1ns / 100ps

module imu_frame_parser_test;
  import ifp_pkg::*;

  localparam int WdogLimit   = 2000;
  localparam int DrainCycles = 20;
  localparam int PhaseBytes  = 500;

  typedef struct packed {
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic signed [15:0] rate_x, rate_y, rate_z;
    logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
  } imu_rec_t;

  typedef logic [8:0][15:0] imu_words_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    imu_rec_t   want;
  } rx_item_t;

  typedef struct {
    bit         stray;
    logic [7:0] ftype;
    logic [15:0] w0, w1, w2, tail;
    bit         bad_sum;
    bit         typed;
    imu_rec_t   want;
  } frame_row_t;

  logic clk;
  logic rst;

  ifp_byte_if rx_ch ();
  ifp_rec_if  rec_ch ();

  imu_frame_parser i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .rec (rec_ch)
  );

  rx_item_t   rx_pend_q [$];
  rx_item_t   rx_cur;
  imu_rec_t   angle_exp_q [$];
  bit         rx_took;
  int         err_cnt;
  int         src_idle_pct;
  int         snk_stall_pct;
  int         bytes_added;

  // predictor state
  logic [7:0]  frame_buf [SumLen];
  count_t      frame_cnt = '0;
  logic [7:0]  frame_sum = '0;
  logic [15:0] accel_lat [NumAxes] = '{default: '0};
  logic [15:0] rate_lat  [NumAxes] = '{default: '0};

  string fld_name [9] = '{"yaw_angle", "pitch_angle", "roll_angle", "rate_z", "rate_y",
                          "rate_x", "accel_z", "accel_y", "accel_x"};

  frame_row_t dir_rows [17];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic parse_byte(input logic [7:0] b, output bit got, output imu_rec_t r);
    logic [15:0] wd [NumAxes];
    got = 1'b0;
    r   = '0;
    if (frame_cnt == 0 && b != HdrByte) return;
    if (frame_cnt < SumLen) begin
      frame_buf[frame_cnt] = b;
      frame_sum = frame_sum + b;
      frame_cnt = frame_cnt + 1'b1;
      return;
    end
    frame_cnt = '0;
    if (b != frame_sum) begin
      frame_sum = '0;
      return;
    end
    frame_sum = '0;
    for (int k = 0; k < NumAxes; k++) wd[k] = {frame_buf[3 + 2 * k], frame_buf[2 + 2 * k]};
    case (frame_buf[1])
      TypeAccel: accel_lat = wd;
      TypeRate:  rate_lat  = wd;
      TypeAngle: begin
        got = 1'b1;
        r = '{accel_lat[0], accel_lat[1], accel_lat[2], rate_lat[0], rate_lat[1], rate_lat[2],
              wd[0], wd[1], wd[2]};
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input bit typed, input imu_rec_t want);
    rx_item_t it;
    it.b     = b;
    it.typed = typed;
    it.want  = want;
    rx_pend_q.insert(rx_pend_q.size(), it);
    bytes_added++;
  endtask

  task automatic push_frame(input logic [7:0] ftype, input logic [15:0] w0, w1, w2, tail,
                            input bit bad_sum, input bit typed, input imu_rec_t want);
    logic [7:0] body [SumLen];
    logic [7:0] sum;
    body = '{HdrByte, ftype, w0[7:0], w0[15:8], w1[7:0], w1[15:8], w2[7:0], w2[15:8],
             tail[7:0], tail[15:8]};
    sum = '0;
    foreach (body[i]) begin
      sum = sum + body[i];
      push_byte(body[i], 1'b0, '0);
    end
    // a bad checksum is a header value where possible, so it must not open a frame
    if (bad_sum) sum = (sum != HdrByte) ? HdrByte : ~sum;
    push_byte(sum, typed, want);
  endtask

  function automatic logic [15:0] rand_word();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic queue_random_stream(input int n_bytes);
    int         sel;
    int         tsel;
    logic [7:0] ftype;
    bytes_added = 0;
    while (bytes_added < n_bytes) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0, '0);
      end else if (sel < 14) begin
        // truncated frame; the next frame's bytes run into it
        push_byte(HdrByte, 1'b0, '0);
        repeat ($urandom_range(0, 9)) push_byte(8'($urandom_range(255)), 1'b0, '0);
      end else begin
        tsel = $urandom_range(99);
        if (tsel < 30)      ftype = TypeAccel;
        else if (tsel < 60) ftype = TypeRate;
        else if (tsel < 90) ftype = TypeAngle;
        else                ftype = 8'($urandom_range(255));
        push_frame(ftype, rand_word(), rand_word(), rand_word(), 16'($urandom_range(16'hFFFF)),
                   $urandom_range(99) < 8, 1'b0, '0);
      end
    end
  endtask

  task automatic wait_sent();
    while (rx_pend_q.size() != 0 || rx_ch.valid) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!rx_ch.valid || rx_took) begin
        if (rx_pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          rx_cur = rx_pend_q.pop_front();
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= rx_cur.b;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
      rec_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : mon
    bit         got;
    imu_rec_t   pred;
    imu_rec_t   want;
    imu_rec_t   seen;
    imu_words_t want_w;
    imu_words_t seen_w;
    if (!rst) begin
      rx_took = rx_ch.valid && rx_ch.ready;
      if (rx_took) begin
        parse_byte(rx_cur.b, got, pred);
        if (got) angle_exp_q.insert(angle_exp_q.size(), rx_cur.typed ? rx_cur.want : pred);
      end
      if (rec_ch.valid && rec_ch.ready) begin
        if (angle_exp_q.size() == 0) begin
          $error("angle record transfer with none expected");
          err_cnt++;
        end else begin
          want = angle_exp_q.pop_front();
          seen = '{rec_ch.accel_x, rec_ch.accel_y, rec_ch.accel_z,
                   rec_ch.rate_x, rec_ch.rate_y, rec_ch.rate_z,
                   rec_ch.roll_angle, rec_ch.pitch_angle, rec_ch.yaw_angle};
          want_w = imu_words_t'(want);
          seen_w = imu_words_t'(seen);
          for (int i = 0; i < 9; i++) begin
            if (want_w[i] !== seen_w[i]) begin
              $error("%s: expected %0d, got %0d", fld_name[i], $signed(want_w[i]),
                     $signed(seen_w[i]));
              err_cnt++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : wdog
    int idle_cyc;
    if (rst || (rx_ch.valid && rx_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
      idle_cyc = 0;
    end else if (rx_pend_q.size() != 0 || rx_ch.valid || angle_exp_q.size() != 0) begin
      idle_cyc++;
    end
    if (idle_cyc >= WdogLimit) begin
      $display("FAIL imu_frame_parser");
      $finish;
    end
  end

  initial begin
    int idle_src [4];
    int idle_snk [4];
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    rec_ch.ready  = 1'b0;
    rx_took       = 1'b0;
    err_cnt       = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    idle_src      = '{0, 67, 0, 22};
    idle_snk      = '{0, 0, 67, 22};

    dir_rows = '{
      '{1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{1'b1, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{1'b0, TypeAngle, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1,
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h7FFF, 16'h8000, 16'h0000}},
      '{1'b0, TypeAccel, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
      '{1'b0, TypeRate, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 1'b0, 1'b0, '0},
      '{1'b0, TypeAngle, 16'hFFFF, 16'h0000, 16'h8000, 16'hFF00, 1'b0, 1'b1,
        '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001,
          16'hFFFF, 16'h0000, 16'h8000}},
      '{1'b0, TypeAccel, 16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 1'b1, 1'b0, '0},
      '{1'b0, TypeAngle, 16'h0001, 16'h0002, 16'h0003, 16'h00FF, 1'b0, 1'b1,
        '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001,
          16'h0001, 16'h0002, 16'h0003}},
      '{1'b0, 8'h00, 16'h1111, 16'h2222, 16'h3333, 16'h0000, 1'b0, 1'b0, '0},
      '{1'b0, 8'hFF, 16'h4444, 16'h5555, 16'h6666, 16'hFFFF, 1'b0, 1'b0, '0},
      '{1'b0, HdrByte, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1'b0, 1'b0, '0},
      '{1'b1, TypeAngle, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
      '{1'b0, TypeAccel, 16'h5555, 16'h5555, 16'h0055, 16'h0000, 1'b0, 1'b0, '0},
      '{1'b0, TypeAngle, 16'h5555, 16'h5555, 16'h5555, 16'h0000, 1'b1, 1'b0, '0},
      '{1'b0, TypeAngle, 16'h0000, 16'h0000, 16'h0000, 16'h5555, 1'b0, 1'b1,
        '{16'h5555, 16'h5555, 16'h0055, 16'h7FFF, 16'h8000, 16'h0001,
          16'h0000, 16'h0000, 16'h0000}},
      '{1'b0, TypeRate, 16'h0000, 16'h0000, 16'h0000, 16'h5555, 1'b0, 1'b0, '0},
      '{1'b0, TypeAngle, 16'h0F0F, 16'hF0F0, 16'hA5A5, 16'h3C3C, 1'b0, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].stray) push_byte(dir_rows[i].ftype, 1'b0, '0);
      else push_frame(dir_rows[i].ftype, dir_rows[i].w0, dir_rows[i].w1, dir_rows[i].w2,
                      dir_rows[i].tail, dir_rows[i].bad_sum, dir_rows[i].typed,
                      dir_rows[i].want);
    end
    wait_sent();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = idle_src[p];
      snk_stall_pct = idle_snk[p];
      queue_random_stream(PhaseBytes);
      wait_sent();
    end

    while (angle_exp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (angle_exp_q.size() != 0) begin
      $error("angle records still expected at end of run");
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS imu_frame_parser");
    end else begin
      $display("FAIL imu_frame_parser");
    end
    $finish;
  end

endmodule
